// ===== hdl/soh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soh_pkg
// Shared types and defaults for the segment versus obstacle edge hit test.
// ----------------------------------------------------------------------------
package soh_pkg;

  localparam int COORD_BITS_DEFAULT  = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic hit;
    logic skipped;
    logic last;
  } soh_result_t;

endpackage

// ===== hdl/soh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soh_front
// Three stage classifier: differences, endpoint match and box tests, then
// the orientation products, then the orientation codes and the verdict.
// ----------------------------------------------------------------------------
module soh_front import soh_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_edge_a_x,
  input  logic signed [COORD_BITS-1:0] in_edge_a_y,
  input  logic signed [COORD_BITS-1:0] in_edge_b_x,
  input  logic signed [COORD_BITS-1:0] in_edge_b_y,
  input  logic                         in_last_edge,
  output logic                         push_valid,
  input  logic                         push_ready,
  output soh_result_t                  push_data
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  typedef enum logic [1:0] {
    ORI_COLLINEAR = 2'd0,
    ORI_POSITIVE  = 2'd1,
    ORI_NEGATIVE  = 2'd2
  } orient_t;

  function automatic logic in_range(input logic signed [COORD_BITS-1:0] q,
                                    input logic signed [COORD_BITS-1:0] p,
                                    input logic signed [COORD_BITS-1:0] r);
    return (q <= p || q <= r) && (q >= p || q >= r);
  endfunction

  function automatic logic signed [DW-1:0] diff(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  logic en1, en2, en3;
  logic s1_valid_r, s2_valid_r, s3_valid_r;

  logic signed [DW-1:0] s1_dy_r [4];
  logic signed [DW-1:0] s1_dx_r [4];
  logic signed [DW-1:0] s1_wx_r [4];
  logic signed [DW-1:0] s1_wy_r [4];
  logic [3:0]           s1_box_r, s2_box_r, s3_box_r;
  logic                 s1_skip_r, s2_skip_r, s3_skip_r;
  logic                 s1_last_r, s2_last_r, s3_last_r;

  logic signed [PW-1:0] s2_pa_r [4];
  logic signed [PW-1:0] s2_pb_r [4];
  orient_t              s3_ori_r [4];

  logic signed [DW-1:0] dy_nxt [4];
  logic signed [DW-1:0] dx_nxt [4];
  logic signed [DW-1:0] wx_nxt [4];
  logic signed [DW-1:0] wy_nxt [4];
  logic [3:0]           box_nxt;
  logic                 skip_nxt;
  orient_t              ori_nxt [4];
  logic                 crossing;

  assign en3      = !s3_valid_r || push_ready;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;

  always_comb begin
    dy_nxt[0] = diff(in_seg_end_y, in_seg_start_y);
    dx_nxt[0] = diff(in_seg_end_x, in_seg_start_x);
    wx_nxt[0] = diff(in_edge_a_x, in_seg_end_x);
    wy_nxt[0] = diff(in_edge_a_y, in_seg_end_y);
    dy_nxt[1] = dy_nxt[0];
    dx_nxt[1] = dx_nxt[0];
    wx_nxt[1] = diff(in_edge_b_x, in_seg_end_x);
    wy_nxt[1] = diff(in_edge_b_y, in_seg_end_y);
    dy_nxt[2] = diff(in_edge_b_y, in_edge_a_y);
    dx_nxt[2] = diff(in_edge_b_x, in_edge_a_x);
    wx_nxt[2] = diff(in_seg_start_x, in_edge_b_x);
    wy_nxt[2] = diff(in_seg_start_y, in_edge_b_y);
    dy_nxt[3] = dy_nxt[2];
    dx_nxt[3] = dx_nxt[2];
    wx_nxt[3] = diff(in_seg_end_x, in_edge_b_x);
    wy_nxt[3] = diff(in_seg_end_y, in_edge_b_y);
    box_nxt[0] = in_range(in_edge_a_x, in_seg_start_x, in_seg_end_x) &&
                 in_range(in_edge_a_y, in_seg_start_y, in_seg_end_y);
    box_nxt[1] = in_range(in_edge_b_x, in_seg_start_x, in_seg_end_x) &&
                 in_range(in_edge_b_y, in_seg_start_y, in_seg_end_y);
    box_nxt[2] = in_range(in_seg_start_x, in_edge_a_x, in_edge_b_x) &&
                 in_range(in_seg_start_y, in_edge_a_y, in_edge_b_y);
    box_nxt[3] = in_range(in_seg_end_x, in_edge_a_x, in_edge_b_x) &&
                 in_range(in_seg_end_y, in_edge_a_y, in_edge_b_y);
    skip_nxt = (in_seg_start_x == in_edge_a_x && in_seg_start_y == in_edge_a_y) ||
               (in_seg_start_x == in_edge_b_x && in_seg_start_y == in_edge_b_y) ||
               (in_seg_end_x == in_edge_a_x && in_seg_end_y == in_edge_a_y) ||
               (in_seg_end_x == in_edge_b_x && in_seg_end_y == in_edge_b_y);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (s2_pa_r[k] == s2_pb_r[k]) begin
        ori_nxt[k] = ORI_COLLINEAR;
      end else if (s2_pa_r[k] > s2_pb_r[k]) begin
        ori_nxt[k] = ORI_POSITIVE;
      end else begin
        ori_nxt[k] = ORI_NEGATIVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_valid;
      if (en2) s2_valid_r <= s1_valid_r;
      if (en3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 4; k++) begin
        s1_dy_r[k] <= dy_nxt[k];
        s1_dx_r[k] <= dx_nxt[k];
        s1_wx_r[k] <= wx_nxt[k];
        s1_wy_r[k] <= wy_nxt[k];
      end
      s1_box_r  <= box_nxt;
      s1_skip_r <= skip_nxt;
      s1_last_r <= in_last_edge;
    end
    if (en2) begin
      for (int k = 0; k < 4; k++) begin
        s2_pa_r[k] <= PW'(s1_dy_r[k]) * PW'(s1_wx_r[k]);
        s2_pb_r[k] <= PW'(s1_dx_r[k]) * PW'(s1_wy_r[k]);
      end
      s2_box_r  <= s1_box_r;
      s2_skip_r <= s1_skip_r;
      s2_last_r <= s1_last_r;
    end
    if (en3) begin
      for (int k = 0; k < 4; k++) begin
        s3_ori_r[k] <= ori_nxt[k];
      end
      s3_box_r  <= s2_box_r;
      s3_skip_r <= s2_skip_r;
      s3_last_r <= s2_last_r;
    end
  end

  always_comb begin
    crossing = (s3_ori_r[0] != s3_ori_r[1] && s3_ori_r[2] != s3_ori_r[3]);
    for (int k = 0; k < 4; k++) begin
      if (s3_ori_r[k] == ORI_COLLINEAR && s3_box_r[k]) crossing = 1'b1;
    end
    push_data.hit     = crossing && !s3_skip_r;
    push_data.skipped = s3_skip_r;
    push_data.last    = s3_last_r;
  end

  assign push_valid = s3_valid_r;

endmodule

// ===== hdl/soh_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soh_queue
// Small first-in first-out queue of per-edge verdicts between the classifier
// and the result stage.
// ----------------------------------------------------------------------------
module soh_queue import soh_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  soh_result_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output soh_result_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  soh_result_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hdl/soh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soh_back
// Result stage: keeps the running hit OR of the current query and holds
// the output register.
// ----------------------------------------------------------------------------
module soh_back import soh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  soh_result_t pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_edge_hit,
  output logic        out_edge_skipped,
  output logic        out_any_hit,
  output logic        out_last_result
);

  logic out_valid_r, acc_r, acc_nxt, any_nxt;
  logic hit_r, skipped_r, any_r, last_r;
  logic load;

  assign pop_ready = !out_valid_r || out_ready;
  assign load      = pop_valid && pop_ready;
  assign any_nxt   = acc_r | pop_data.hit;
  assign acc_nxt   = pop_data.last ? 1'b0 : any_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
    end else begin
      if (pop_ready) out_valid_r <= pop_valid;
      if (load) acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit_r     <= pop_data.hit;
      skipped_r <= pop_data.skipped;
      any_r     <= any_nxt;
      last_r    <= pop_data.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_edge_hit     = hit_r;
  assign out_edge_skipped = skipped_r;
  assign out_any_hit      = any_r;
  assign out_last_result  = last_r;

endmodule

// ===== hdl/segment_obstacle_hit_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_obstacle_hit_test_unit
// Tests a query segment against a stream of obstacle edges, one per beat.
// ----------------------------------------------------------------------------
// Each input beat carries the query segment, one obstacle edge and a flag
// that marks the last edge of the query. Each beat yields exactly one
// result beat: the hit for that edge, whether the edge was skipped for
// sharing an endpoint with the query, the running OR of hits within the
// query, and a copy of the last flag. The running OR clears after the beat
// marked last.
// Throughput is one beat per cycle while the receiver does not stall; the
// classifier is a three stage pipeline (differences, products, orientation
// compares) whose multiplier products are registered in the second stage.
// A QUEUE_DEPTH entry queue (four by default) separates the classifier from the output register.
// When the receiver stalls the queue fills, then the pipeline holds, then
// in_ready drops; nothing is lost. Synchronous reset empties the pipeline
// and the queue and clears the running OR.
// ----------------------------------------------------------------------------
module segment_obstacle_hit_test_unit import soh_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic signed [COORD_BITS-1:0] in_edge_a_x,
  input  logic signed [COORD_BITS-1:0] in_edge_a_y,
  input  logic signed [COORD_BITS-1:0] in_edge_b_x,
  input  logic signed [COORD_BITS-1:0] in_edge_b_y,
  input  logic                         in_last_edge,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_edge_hit,
  output logic                         out_edge_skipped,
  output logic                         out_any_hit,
  output logic                         out_last_result
);

  logic        push_valid, push_ready, pop_valid, pop_ready;
  soh_result_t push_data, pop_data;

  soh_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_seg_start_x(in_seg_start_x),
    .in_seg_start_y(in_seg_start_y),
    .in_seg_end_x  (in_seg_end_x),
    .in_seg_end_y  (in_seg_end_y),
    .in_edge_a_x   (in_edge_a_x),
    .in_edge_a_y   (in_edge_a_y),
    .in_edge_b_x   (in_edge_b_x),
    .in_edge_b_y   (in_edge_b_y),
    .in_last_edge  (in_last_edge),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  soh_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  soh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_edge_hit    (out_edge_hit),
    .out_edge_skipped(out_edge_skipped),
    .out_any_hit     (out_any_hit),
    .out_last_result (out_last_result)
  );

endmodule

// ===== hdl/soh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soh_checker
// Port level assertions for the hit test unit, bound to the top level.
// ----------------------------------------------------------------------------
module soh_checker import soh_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [COORD_BITS-1:0] in_seg_start_x,
  input logic signed [COORD_BITS-1:0] in_seg_start_y,
  input logic signed [COORD_BITS-1:0] in_seg_end_x,
  input logic signed [COORD_BITS-1:0] in_seg_end_y,
  input logic signed [COORD_BITS-1:0] in_edge_a_x,
  input logic signed [COORD_BITS-1:0] in_edge_a_y,
  input logic signed [COORD_BITS-1:0] in_edge_b_x,
  input logic signed [COORD_BITS-1:0] in_edge_b_y,
  input logic                         in_last_edge,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_edge_hit,
  input logic                         out_edge_skipped,
  input logic                         out_any_hit,
  input logic                         out_last_result
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_hit) &&
    $stable(out_edge_skipped) && $stable(out_any_hit) && $stable(out_last_result))
    else $error("stalled result beat changed");

  a_skip_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_skipped |-> !out_edge_hit)
    else $error("skipped edge reported a hit");

  a_hit_in_or: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_hit |-> out_any_hit)
    else $error("edge hit missing from running OR");

endmodule

bind segment_obstacle_hit_test_unit soh_checker #(.COORD_BITS(COORD_BITS)) u_soh_checker (.*);
